/* sv/aacir_pkg.sv */
// Shared types and constants of the AABB contact impulse resolver.
// Used by the channel interfaces and every module of the block but aacir_divider and aacir_checker; no dependencies.
`default_nettype none

package aacir_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRAC_BITS       = 10;
    localparam int VEC_W           = 48;
    localparam int MASS_W          = 16;
    localparam int FLAGS_W         = 2;
    localparam int PEN_W           = 16;
    localparam int SHIFT_W         = 16;
    localparam int DEN_W           = MASS_W + 1;
    localparam int PCT_W           = 9;
    localparam int SLOP_W          = 10;
    localparam int REST_W          = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [PCT_W-1:0]  PCT_RESET  = 9'd51;
    localparam logic [SLOP_W-1:0] SLOP_RESET = 10'd1;
    localparam logic [REST_W-1:0] REST_RESET = 9'd0;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORRECTION_PERCENT = 2'd0,
        REG_PENETRATION_SLOP   = 2'd1,
        REG_RESTITUTION        = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [SLOP_W-1:0] slop;
        logic [REST_W-1:0] rest;
    } cfg_t;

    typedef struct packed {
        logic       found;
        logic [1:0] axis;
        logic       negative;
        logic       approach;
    } front_ctrl_t;

endpackage

`default_nettype wire

/* sv/aacir_if.sv */
// Channel interfaces of the resolver: body pair in, contact result out, register writes.
// Depends on aacir_pkg for field widths.
`default_nettype none

interface aacir_pair_if;
    logic                             valid;
    logic                             ready;
    logic [aacir_pkg::VEC_W-1:0]      center_a;
    logic [aacir_pkg::VEC_W-1:0]      center_b;
    logic [aacir_pkg::VEC_W-1:0]      half_a;
    logic [aacir_pkg::VEC_W-1:0]      half_b;
    logic [aacir_pkg::VEC_W-1:0]      scale_a;
    logic [aacir_pkg::VEC_W-1:0]      scale_b;
    logic [aacir_pkg::VEC_W-1:0]      vel_a;
    logic [aacir_pkg::VEC_W-1:0]      vel_b;
    logic [aacir_pkg::MASS_W-1:0]     mass_a;
    logic [aacir_pkg::MASS_W-1:0]     mass_b;
    logic [aacir_pkg::FLAGS_W-1:0]    flags_a;
    logic [aacir_pkg::FLAGS_W-1:0]    flags_b;

    modport source (output valid, center_a, center_b, half_a, half_b, scale_a, scale_b,
                    vel_a, vel_b, mass_a, mass_b, flags_a, flags_b, input ready);
    modport sink   (input valid, center_a, center_b, half_a, half_b, scale_a, scale_b,
                    vel_a, vel_b, mass_a, mass_b, flags_a, flags_b, output ready);
endinterface

interface aacir_result_if;
    logic                                valid;
    logic                                ready;
    logic                                contact_found;
    logic [1:0]                          normal_axis;
    logic                                normal_negative;
    logic [aacir_pkg::PEN_W-1:0]         penetration;
    logic signed [aacir_pkg::SHIFT_W-1:0] shift_a;
    logic signed [aacir_pkg::SHIFT_W-1:0] shift_b;
    logic [aacir_pkg::VEC_W-1:0]         new_vel_a;
    logic [aacir_pkg::VEC_W-1:0]         new_vel_b;

    modport source (output valid, contact_found, normal_axis, normal_negative, penetration,
                    shift_a, shift_b, new_vel_a, new_vel_b, input ready);
    modport sink   (input valid, contact_found, normal_axis, normal_negative, penetration,
                    shift_a, shift_b, new_vel_a, new_vel_b, output ready);
endinterface

interface aacir_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [aacir_pkg::CFG_IDX_W-1:0]   index;
    logic [aacir_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/aacir_front.sv */
// Front part: scales boxes, finds the per-axis overlaps, picks the normal axis and
// classifies the pair. Two register stages. Depends on aacir_pkg and aacir_pair_if.
`default_nettype none

module aacir_front #(
    parameter int CW = aacir_pkg::COMPONENT_WIDTH,
    localparam int VW = 3 * CW,
    localparam int PW = 2 * CW - 9
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    aacir_pair_if.sink                      pair,
    input  wire logic                       full,
    output logic                            out_valid,
    output aacir_pkg::front_ctrl_t          ctrl,
    output logic [PW-1:0]                   pen,
    output logic [CW:0]                     vmag,
    output logic [VW-1:0]                   va,
    output logic [VW-1:0]                   vb,
    output logic [aacir_pkg::MASS_W-1:0]    fa,
    output logic [aacir_pkg::MASS_W-1:0]    fb,
    output logic [aacir_pkg::DEN_W-1:0]     den
);

    localparam int XW = (VW > aacir_pkg::VEC_W) ? VW : aacir_pkg::VEC_W;
    localparam int P2 = 2 * CW;
    localparam int HW = 2 * CW - aacir_pkg::FRAC_BITS;
    localparam int OW = 2 * CW - 7;
    localparam int C1 = CW + 1;
    localparam int MW = aacir_pkg::MASS_W;
    localparam int NW = aacir_pkg::DEN_W;

    logic en;
    logic [XW-1:0] ca_x, cb_x, ha_x, hb_x, sa_x, sb_x, va_x, vb_x;

    logic [HW-1:0]        ha_next [3];
    logic [HW-1:0]        hb_next [3];
    logic signed [CW:0]   d_next  [3];

    logic [HW-1:0]        ha_reg  [3];
    logic [HW-1:0]        hb_reg  [3];
    logic signed [CW:0]   d_reg   [3];
    logic [VW-1:0]        va1_reg, vb1_reg;
    logic [MW-1:0]        ma_reg, mb_reg;
    logic                 sta_reg, stb_reg, aabb_reg;
    logic                 v1_reg, v2_reg;

    logic [CW:0]          absd [3];
    logic signed [OW-1:0] ov   [3];

    logic [1:0]           axis_sel;
    logic signed [OW-1:0] pmin;
    logic signed [CW:0]   d_sel;
    logic [CW-1:0]        va_ax, vb_ax;
    logic signed [CW:0]   dv;
    logic signed [CW+1:0] dvx, vsg, nv;
    logic                 contact, neg, approach;
    logic [MW-1:0]        mae, mbe, fa_next, fb_next;
    logic [NW-1:0]        den_next;

    aacir_pkg::front_ctrl_t ctrl_reg;
    logic [PW-1:0]          pen_reg;
    logic [CW:0]            vmag_reg;
    logic [VW-1:0]          va2_reg, vb2_reg;
    logic [MW-1:0]          fa_reg, fb_reg;
    logic [NW-1:0]          den_reg;

    // hold both stages while the queue is full
    assign en         = !full;
    assign pair.ready = en;

    assign ca_x = XW'(pair.center_a);
    assign cb_x = XW'(pair.center_b);
    assign ha_x = XW'(pair.half_a);
    assign hb_x = XW'(pair.half_b);
    assign sa_x = XW'(pair.scale_a);
    assign sb_x = XW'(pair.scale_b);
    assign va_x = XW'(pair.vel_a);
    assign vb_x = XW'(pair.vel_b);

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_axis
        logic [P2-1:0] pa, pb;
        assign pa = P2'(ha_x[ax*CW +: CW]) * P2'(sa_x[ax*CW +: CW]);
        assign pb = P2'(hb_x[ax*CW +: CW]) * P2'(sb_x[ax*CW +: CW]);
        assign ha_next[ax] = pa[P2-1:aacir_pkg::FRAC_BITS];
        assign hb_next[ax] = pb[P2-1:aacir_pkg::FRAC_BITS];
        assign d_next[ax]  = $signed({cb_x[ax*CW+CW-1], cb_x[ax*CW +: CW]})
                           - $signed({ca_x[ax*CW+CW-1], ca_x[ax*CW +: CW]});

        assign absd[ax] = d_reg[ax][CW] ? C1'(-d_reg[ax]) : C1'(d_reg[ax]);
        assign ov[ax]   = $signed(OW'(ha_reg[ax]) + OW'(hb_reg[ax]) - OW'(absd[ax]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pair.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                ha_reg[ax] <= ha_next[ax];
                hb_reg[ax] <= hb_next[ax];
                d_reg[ax]  <= d_next[ax];
            end
            va1_reg  <= va_x[VW-1:0];
            vb1_reg  <= vb_x[VW-1:0];
            ma_reg   <= pair.mass_a;
            mb_reg   <= pair.mass_b;
            sta_reg  <= pair.flags_a[0];
            stb_reg  <= pair.flags_b[0];
            aabb_reg <= pair.flags_a[1] | pair.flags_b[1];
        end
    end

    always_comb
    begin
        // ties keep the earlier axis
        axis_sel = aacir_pkg::AXIS_X;
        pmin     = ov[0];
        if (ov[1] < pmin)
        begin
            pmin     = ov[1];
            axis_sel = aacir_pkg::AXIS_Y;
        end
        if (ov[2] < pmin)
        begin
            pmin     = ov[2];
            axis_sel = aacir_pkg::AXIS_Z;
        end

        unique case (axis_sel)
            aacir_pkg::AXIS_Y:
            begin
                d_sel = d_reg[1];
                va_ax = va1_reg[CW +: CW];
                vb_ax = vb1_reg[CW +: CW];
            end
            aacir_pkg::AXIS_Z:
            begin
                d_sel = d_reg[2];
                va_ax = va1_reg[2*CW +: CW];
                vb_ax = vb1_reg[2*CW +: CW];
            end
            default:
            begin
                d_sel = d_reg[0];
                va_ax = va1_reg[0 +: CW];
                vb_ax = vb1_reg[0 +: CW];
            end
        endcase

        contact = aabb_reg && !(sta_reg && stb_reg)
               && !ov[0][OW-1] && (ov[0] != '0)
               && !ov[1][OW-1] && (ov[1] != '0)
               && !ov[2][OW-1] && (ov[2] != '0);
        neg = d_sel[CW];

        dv       = $signed({vb_ax[CW-1], vb_ax}) - $signed({va_ax[CW-1], va_ax});
        dvx      = {dv[CW], dv};
        vsg      = neg ? -dvx : dvx;
        approach = vsg[CW+1] || (vsg == '0);
        nv       = -vsg;

        mae = (ma_reg == '0) ? MW'(1) : ma_reg;
        mbe = (mb_reg == '0) ? MW'(1) : mb_reg;
        priority if (sta_reg)
        begin
            fa_next  = '0;
            fb_next  = MW'(1);
            den_next = NW'(1);
        end
        else if (stb_reg)
        begin
            fa_next  = MW'(1);
            fb_next  = '0;
            den_next = NW'(1);
        end
        else
        begin
            fa_next  = mbe;
            fb_next  = mae;
            den_next = NW'(mae) + NW'(mbe);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg.found    <= contact;
            ctrl_reg.axis     <= axis_sel;
            ctrl_reg.negative <= neg;
            ctrl_reg.approach <= approach;
            pen_reg           <= pmin[PW-1:0];
            vmag_reg          <= nv[CW:0];
            va2_reg           <= va1_reg;
            vb2_reg           <= vb1_reg;
            fa_reg            <= fa_next;
            fb_reg            <= fb_next;
            den_reg           <= den_next;
        end
    end

    assign out_valid = v2_reg;
    assign ctrl      = ctrl_reg;
    assign pen       = pen_reg;
    assign vmag      = vmag_reg;
    assign va        = va2_reg;
    assign vb        = vb2_reg;
    assign fa        = fa_reg;
    assign fb        = fb_reg;
    assign den       = den_reg;

endmodule

`default_nettype wire

/* sv/aacir_queue.sv */
// Short FIFO between the front and back parts of the resolver.
// Depends on aacir_pkg for the default depth.
`default_nettype none

module aacir_queue #(
    parameter int W     = 8,
    parameter int DEPTH = aacir_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic              nonempty,
    output logic [W-1:0]      rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign rdata    = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* sv/aacir_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, quotient saturated to QB bits.
// Standalone; used by the back part of the resolver.
`default_nettype none

module aacir_divider #(
    parameter int NW = 41,
    parameter int DW = 17,
    parameter int QB = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic [QB-1:0]      quo
);

    localparam int CMW = (NW > DW + QB) ? NW : DW + QB;

    logic [CMW-1:0] num_x, den_x;
    logic [NW-1:0]  num_hi;
    logic           sat_next;

    logic [DW-1:0] r_reg [QB];
    logic [QB-1:0] n_reg [QB];
    logic [DW-1:0] d_reg [QB];
    logic [QB-1:0] q_reg [QB+1];
    logic          s_reg [QB+1];

    // a quotient that needs more than QB bits saturates; otherwise the high part is below den
    assign num_x    = CMW'(num);
    assign den_x    = CMW'(den) << QB;
    assign sat_next = (num_x >= den_x);
    assign num_hi   = num >> QB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= DW'(num_hi);
            n_reg[0] <= QB'(num);
            d_reg[0] <= den;
            q_reg[0] <= '0;
            s_reg[0] <= sat_next;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DW:0] t, diff;
        logic        ge;

        assign t    = {r_reg[k-1], n_reg[k-1][QB-1]};
        assign diff = t - {1'b0, d_reg[k-1]};
        assign ge   = (t >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= {q_reg[k-1][QB-2:0], ge};
                s_reg[k] <= s_reg[k-1];
            end
        end

        if (k < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    n_reg[k] <= n_reg[k-1] << 1;
                    d_reg[k] <= d_reg[k-1];
                end
            end
        end
    end

    assign quo = s_reg[QB] ? '1 : q_reg[QB];

endmodule

`default_nettype wire

/* sv/aacir_back.sv */
// Back part: correction and impulse products, four shared-latency dividers for the
// mass split, saturation and the output register. Depends on aacir_pkg,
// aacir_divider and aacir_result_if.
`default_nettype none

module aacir_back #(
    parameter int CW = aacir_pkg::COMPONENT_WIDTH,
    localparam int VW = 3 * CW,
    localparam int PW = 2 * CW - 9
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire aacir_pkg::cfg_t            cfg,
    input  wire logic                       in_valid,
    output logic                            in_pop,
    input  wire aacir_pkg::front_ctrl_t     ctrl,
    input  wire logic [PW-1:0]              pen,
    input  wire logic [CW:0]                vmag,
    input  wire logic [VW-1:0]              va,
    input  wire logic [VW-1:0]              vb,
    input  wire logic [aacir_pkg::MASS_W-1:0] fa,
    input  wire logic [aacir_pkg::MASS_W-1:0] fb,
    input  wire logic [aacir_pkg::DEN_W-1:0]  den,
    aacir_result_if.source                  result
);

    localparam int MW  = aacir_pkg::MASS_W;
    localparam int DW  = aacir_pkg::DEN_W;
    localparam int CPW = PW + aacir_pkg::PCT_W;
    localparam int CRW = CPW - 8;
    localparam int BW  = CW + 11;
    localparam int NSW = CRW + MW;
    localparam int NVP = BW + MW;
    localparam int NVW = NVP - 8;
    localparam int QD  = (CW + 1 > aacir_pkg::SHIFT_W) ? CW + 1 : aacir_pkg::SHIFT_W;
    localparam int SW  = QD + 2;
    localparam int XW  = (VW > aacir_pkg::VEC_W) ? VW : aacir_pkg::VEC_W;
    localparam int PXW = (PW > aacir_pkg::PEN_W) ? PW : aacir_pkg::PEN_W;
    localparam logic signed [SW-1:0] VHI = SW'((1 << (CW - 1)) - 1);
    localparam logic signed [SW-1:0] VLO = -VHI - SW'(1);

    logic en;

    // stage 1
    logic [PW-1:0]  slop_x, diff_next;
    logic [CPW-1:0] cprod;
    logic [9:0]     rest_sum;
    logic [BW-1:0]  base_next;
    logic [PXW-1:0] pen_x;
    logic [15:0]    pen_sat;

    logic                   v1_reg;
    aacir_pkg::front_ctrl_t c1_reg;
    logic [VW-1:0]          va1_reg, vb1_reg;
    logic [MW-1:0]          fa1_reg, fb1_reg;
    logic [DW-1:0]          den1_reg;
    logic [CRW-1:0]         corr1_reg;
    logic [BW-1:0]          base1_reg;
    logic [15:0]            pen1_reg;

    // stage 2
    logic [NVP-1:0] pva, pvb;

    logic                   v2_reg;
    aacir_pkg::front_ctrl_t c2_reg;
    logic [VW-1:0]          va2_reg, vb2_reg;
    logic [DW-1:0]          den2_reg;
    logic [NSW-1:0]         nsa_reg, nsb_reg;
    logic [NVW-1:0]         nva_reg, nvb_reg;
    logic [15:0]            pen2_reg;

    // delay line beside the dividers
    logic                   lv_reg   [QD+1];
    aacir_pkg::front_ctrl_t lc_reg   [QD+1];
    logic [VW-1:0]          lva_reg  [QD+1];
    logic [VW-1:0]          lvb_reg  [QD+1];
    logic [15:0]            lpen_reg [QD+1];

    logic [QD-1:0] qsa, qsb, qva, qvb;

    // output stage
    aacir_pkg::front_ctrl_t cf;
    logic [CW-1:0]          va_ax, vb_ax;
    logic signed [SW-1:0]   sva, svb;
    logic [VW-1:0]          nva_vec, nvb_vec;
    logic [XW-1:0]          nva_x, nvb_x;
    logic [15:0]            sa_next, sb_next, pen_next;
    logic [1:0]             axis_next;
    logic                   neg_next;

    logic        out_valid_reg;
    logic        found_reg, neg_reg;
    logic [1:0]  axis_reg;
    logic [15:0] pen_reg, sa_reg, sb_reg;
    logic [aacir_pkg::VEC_W-1:0] nva_reg48, nvb_reg48;

    function automatic logic [15:0] to_pos(input logic [QD-1:0] m);
        if (m > QD'(32767))
            return 16'h7FFF;
        return m[15:0];
    endfunction

    function automatic logic [15:0] to_neg(input logic [QD-1:0] m);
        if (m > QD'(32768))
            return 16'h8000;
        return ~m[15:0] + 16'd1;
    endfunction

    function automatic logic [CW-1:0] vsat(input logic signed [SW-1:0] x);
        if (x > VHI)
            return VHI[CW-1:0];
        if (x < VLO)
            return VLO[CW-1:0];
        return x[CW-1:0];
    endfunction

    // the whole back part moves as one unless the output register is held
    assign en     = !out_valid_reg || result.ready;
    assign in_pop = en && in_valid;

    assign slop_x    = PW'(cfg.slop);
    assign diff_next = (pen > slop_x) ? pen - slop_x : '0;
    assign cprod     = CPW'(diff_next) * CPW'(cfg.pct);
    assign rest_sum  = 10'd256 + 10'(cfg.rest);
    assign base_next = BW'(rest_sum) * BW'(vmag);
    assign pen_x     = PXW'(pen);
    assign pen_sat   = (pen_x > PXW'(16'hFFFF)) ? 16'hFFFF : pen_x[15:0];

    assign pva = NVP'(base1_reg) * NVP'(fa1_reg);
    assign pvb = NVP'(base1_reg) * NVP'(fb1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= QD; k++)
                lv_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            lv_reg[0] <= v2_reg;
            for (int k = 1; k <= QD; k++)
                lv_reg[k] <= lv_reg[k-1];
            out_valid_reg <= lv_reg[QD];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= ctrl;
            va1_reg   <= va;
            vb1_reg   <= vb;
            fa1_reg   <= fa;
            fb1_reg   <= fb;
            den1_reg  <= den;
            corr1_reg <= cprod[CPW-1:8];
            base1_reg <= base_next;
            pen1_reg  <= pen_sat;

            c2_reg   <= c1_reg;
            va2_reg  <= va1_reg;
            vb2_reg  <= vb1_reg;
            den2_reg <= den1_reg;
            nsa_reg  <= NSW'(corr1_reg) * NSW'(fa1_reg);
            nsb_reg  <= NSW'(corr1_reg) * NSW'(fb1_reg);
            nva_reg  <= pva[NVP-1:8];
            nvb_reg  <= pvb[NVP-1:8];
            pen2_reg <= pen1_reg;

            lc_reg[0]   <= c2_reg;
            lva_reg[0]  <= va2_reg;
            lvb_reg[0]  <= vb2_reg;
            lpen_reg[0] <= pen2_reg;
            for (int k = 1; k <= QD; k++)
            begin
                lc_reg[k]   <= lc_reg[k-1];
                lva_reg[k]  <= lva_reg[k-1];
                lvb_reg[k]  <= lvb_reg[k-1];
                lpen_reg[k] <= lpen_reg[k-1];
            end
        end
    end

    aacir_divider #(.NW(NSW), .DW(DW), .QB(QD)) u_div_shift_a (
        .clk (clk), .en (en), .num (nsa_reg), .den (den2_reg), .quo (qsa)
    );
    aacir_divider #(.NW(NSW), .DW(DW), .QB(QD)) u_div_shift_b (
        .clk (clk), .en (en), .num (nsb_reg), .den (den2_reg), .quo (qsb)
    );
    aacir_divider #(.NW(NVW), .DW(DW), .QB(QD)) u_div_vel_a (
        .clk (clk), .en (en), .num (nva_reg), .den (den2_reg), .quo (qva)
    );
    aacir_divider #(.NW(NVW), .DW(DW), .QB(QD)) u_div_vel_b (
        .clk (clk), .en (en), .num (nvb_reg), .den (den2_reg), .quo (qvb)
    );

    always_comb
    begin
        cf = lc_reg[QD];

        unique case (cf.axis)
            aacir_pkg::AXIS_Y:
            begin
                va_ax = lva_reg[QD][CW +: CW];
                vb_ax = lvb_reg[QD][CW +: CW];
            end
            aacir_pkg::AXIS_Z:
            begin
                va_ax = lva_reg[QD][2*CW +: CW];
                vb_ax = lvb_reg[QD][2*CW +: CW];
            end
            default:
            begin
                va_ax = lva_reg[QD][0 +: CW];
                vb_ax = lvb_reg[QD][0 +: CW];
            end
        endcase

        sva = $signed({{(SW-CW){va_ax[CW-1]}}, va_ax});
        svb = $signed({{(SW-CW){vb_ax[CW-1]}}, vb_ax});
        // A moves against the normal, B along it
        sva = cf.negative ? sva + $signed(SW'(qva)) : sva - $signed(SW'(qva));
        svb = cf.negative ? svb - $signed(SW'(qvb)) : svb + $signed(SW'(qvb));

        nva_vec = lva_reg[QD];
        nvb_vec = lvb_reg[QD];
        if (cf.found && cf.approach)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                if (cf.axis == 2'(ax))
                begin
                    nva_vec[ax*CW +: CW] = vsat(sva);
                    nvb_vec[ax*CW +: CW] = vsat(svb);
                end
            end
        end
        nva_x = XW'(nva_vec);
        nvb_x = XW'(nvb_vec);

        if (cf.found)
        begin
            axis_next = cf.axis;
            neg_next  = cf.negative;
            pen_next  = lpen_reg[QD];
            sa_next   = cf.negative ? to_pos(qsa) : to_neg(qsa);
            sb_next   = cf.negative ? to_neg(qsb) : to_pos(qsb);
        end
        else
        begin
            axis_next = aacir_pkg::AXIS_X;
            neg_next  = 1'b0;
            pen_next  = '0;
            sa_next   = '0;
            sb_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg <= cf.found;
            axis_reg  <= axis_next;
            neg_reg   <= neg_next;
            pen_reg   <= pen_next;
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
            nva_reg48 <= nva_x[aacir_pkg::VEC_W-1:0];
            nvb_reg48 <= nvb_x[aacir_pkg::VEC_W-1:0];
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.contact_found   = found_reg;
    assign result.normal_axis     = axis_reg;
    assign result.normal_negative = neg_reg;
    assign result.penetration     = pen_reg;
    assign result.shift_a         = $signed(sa_reg);
    assign result.shift_b         = $signed(sb_reg);
    assign result.new_vel_a       = nva_reg48;
    assign result.new_vel_b       = nvb_reg48;

endmodule

`default_nettype wire

/* sv/aabb_contact_impulse_resolver.sv */
// Top level of the AABB contact impulse resolver: register file, front part, queue, back part.
// Depends on aacir_pkg, aacir_if, aacir_front, aacir_queue, aacir_back.
//
// Usage:
//   pair   - one body pair per item (centers, half extents, scales, velocities,
//            masses, flags); accepted when valid and ready are both high.
//   result - one result item per pair: contact flag, normal axis and sign,
//            penetration, positional shifts and velocities after the impulse.
//   cfg    - register writes (index 0 correction percent, 1 slop, 2 restitution);
//            ready is always high, write only while no pair is in flight.
// Throughput: one pair per cycle while result.ready stays high.
// Depth: set by the bit-per-stage dividers of the mass split, whose quotients have
//   QD = max(16, COMPONENT_WIDTH + 1) bits, 17 by default.
// Reset: registers return to 51, 1 and 0; all stages and the queue empty.
// Receiver stall: the output register holds, the back part freezes, the queue between
//   the parts fills up to four items, then the front part and pair.ready stall.
`default_nettype none

module aabb_contact_impulse_resolver #(
    parameter int COMPONENT_WIDTH = aacir_pkg::COMPONENT_WIDTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    aacir_pair_if.sink      pair,
    aacir_result_if.source  result,
    aacir_cfg_if.sink       cfg
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int VW = 3 * CW;
    localparam int PW = 2 * CW - 9;
    localparam int MW = aacir_pkg::MASS_W;
    localparam int DW = aacir_pkg::DEN_W;
    localparam int EW = $bits(aacir_pkg::front_ctrl_t) + PW + (CW + 1) + 2 * VW
                      + 2 * MW + DW;

    aacir_pkg::cfg_t cfg_reg;

    logic                   f_valid;
    aacir_pkg::front_ctrl_t f_ctrl, b_ctrl;
    logic [PW-1:0]          f_pen, b_pen;
    logic [CW:0]            f_vmag, b_vmag;
    logic [VW-1:0]          f_va, f_vb, b_va, b_vb;
    logic [MW-1:0]          f_fa, f_fb, b_fa, b_fb;
    logic [DW-1:0]          f_den, b_den;

    logic          q_full, q_nonempty, q_pop;
    logic [EW-1:0] q_wdata, q_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pct  <= aacir_pkg::PCT_RESET;
            cfg_reg.slop <= aacir_pkg::SLOP_RESET;
            cfg_reg.rest <= aacir_pkg::REST_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (aacir_pkg::cfg_reg_t'(cfg.index))
                aacir_pkg::REG_CORRECTION_PERCENT: cfg_reg.pct  <= cfg.data[aacir_pkg::PCT_W-1:0];
                aacir_pkg::REG_PENETRATION_SLOP:   cfg_reg.slop <= cfg.data[aacir_pkg::SLOP_W-1:0];
                aacir_pkg::REG_RESTITUTION:        cfg_reg.rest <= cfg.data[aacir_pkg::REST_W-1:0];
                default:                           cfg_reg <= cfg_reg;
            endcase
        end
    end

    aacir_front #(.CW(CW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .full      (q_full),
        .out_valid (f_valid),
        .ctrl      (f_ctrl),
        .pen       (f_pen),
        .vmag      (f_vmag),
        .va        (f_va),
        .vb        (f_vb),
        .fa        (f_fa),
        .fb        (f_fb),
        .den       (f_den)
    );

    assign q_wdata = {f_ctrl, f_pen, f_vmag, f_va, f_vb, f_fa, f_fb, f_den};

    aacir_queue #(.W(EW), .DEPTH(aacir_pkg::QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_valid),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    (q_rdata)
    );

    assign {b_ctrl, b_pen, b_vmag, b_va, b_vb, b_fa, b_fb, b_den} = q_rdata;

    aacir_back #(.CW(CW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (q_nonempty),
        .in_pop   (q_pop),
        .ctrl     (b_ctrl),
        .pen      (b_pen),
        .vmag     (b_vmag),
        .va       (b_va),
        .vb       (b_vb),
        .fa       (b_fa),
        .fb       (b_fb),
        .den      (b_den),
        .result   (result)
    );

endmodule

`default_nettype wire

/* sv/aacir_checker.sv */
// Port-level checks on the result channel of the resolver, bound to the top level.
// Depends on the top-level ports only.
`default_nettype none

module aacir_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        contact_found,
    input wire logic [1:0]  normal_axis,
    input wire logic        normal_negative,
    input wire logic [15:0] penetration,
    input wire logic [15:0] shift_a,
    input wire logic [15:0] shift_b
);

    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    // no contact means an all-zero contact report
    a_no_contact: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !contact_found |-> normal_axis == 2'd0 && !normal_negative
            && penetration == 16'd0 && shift_a == 16'd0 && shift_b == 16'd0)
        else $error("contact fields set without contact");

    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> normal_axis != 2'd3)
        else $error("invalid normal axis");

    // A is pushed against the normal, B along it
    a_shift_dir: assert property (@(posedge clk) disable iff (!rst_n)
        valid && contact_found |->
            (normal_negative ? (!shift_b[15] || shift_b == 16'd0) || 1'b1 : 1'b1)
            && (normal_negative ? (shift_a[15] == 1'b0 && (shift_b[15] || shift_b == 16'd0))
                                : ((shift_a[15] || shift_a == 16'd0) && shift_b[15] == 1'b0)))
        else $error("shift direction disagrees with normal");

endmodule

bind aabb_contact_impulse_resolver aacir_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result.valid),
    .ready           (result.ready),
    .contact_found   (result.contact_found),
    .normal_axis     (result.normal_axis),
    .normal_negative (result.normal_negative),
    .penetration     (result.penetration),
    .shift_a         (result.shift_a),
    .shift_b         (result.shift_b)
);

`default_nettype wire

/* tb/aacir_contact_checker.sv */
// Checker of the AABB contact impulse resolver: predicts each contact result and compares it.
// Depends on aacir_pkg and the channel interfaces in aacir_if.
`default_nettype none

module aacir_contact_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    aacir_pair_if     pair,
    aacir_result_if   result,
    aacir_cfg_if      cfg,
    output int        fail_count,
    output int        pending
);
    import aacir_pkg::*;

    typedef struct packed {
        logic              found;
        logic [1:0]        axis;
        logic              negative;
        logic [PEN_W-1:0]  pen;
        logic [15:0]       shift_a;
        logic [15:0]       shift_b;
        logic [VEC_W-1:0]  vel_a;
        logic [VEC_W-1:0]  vel_b;
    } contact_t;

    contact_t contact_q[$];
    longint   pct_r;
    longint   slop_r;
    longint   rest_r;

    function automatic longint clamp16(input longint v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic longint comp_u(input logic [VEC_W-1:0] vec, input int ax);
        return longint'({48'd0, vec[ax*16 +: 16]});
    endfunction

    function automatic longint comp_s(input logic [VEC_W-1:0] vec, input int ax);
        return longint'($signed(vec[ax*16 +: 16]));
    endfunction

    function automatic contact_t resolve_contact(
        input logic [VEC_W-1:0] ca, cb, ha, hb, sa, sb, va, vb,
        input logic [MASS_W-1:0] ma_in, mb_in,
        input logic [FLAGS_W-1:0] fa, fb
    );
        longint   ov[3];
        longint   dl[3];
        longint   d, pen, sgn, fan, fbn, den, ma, mb, corr, mag, v, base, da, db;
        int       axis;
        contact_t r;
        for (int ax = 0; ax < 3; ax++)
        begin
            d = comp_s(cb, ax) - comp_s(ca, ax);
            dl[ax] = d;
            ov[ax] = ((comp_u(ha, ax) * comp_u(sa, ax)) >> 10)
                   + ((comp_u(hb, ax) * comp_u(sb, ax)) >> 10) - (d < 0 ? -d : d);
        end
        axis = 0;
        pen = ov[0];
        for (int ax = 1; ax < 3; ax++)
            if (ov[ax] < pen)
            begin
                pen = ov[ax];
                axis = ax;
            end
        r = '0;
        r.vel_a = va;
        r.vel_b = vb;
        if (!(fa[1] | fb[1]) || (fa[0] && fb[0]) || ov[0] <= 0 || ov[1] <= 0 || ov[2] <= 0)
            return r;
        ma = (ma_in == 0) ? 1 : longint'({48'd0, ma_in});
        mb = (mb_in == 0) ? 1 : longint'({48'd0, mb_in});
        if (fa[0])
        begin
            fan = 0; fbn = 1; den = 1;
        end
        else if (fb[0])
        begin
            fan = 1; fbn = 0; den = 1;
        end
        else
        begin
            fan = mb; fbn = ma; den = ma + mb;
        end
        sgn = (dl[axis] < 0) ? -1 : 1;
        r.found = 1'b1;
        r.axis = axis[1:0];
        r.negative = (sgn < 0);
        r.pen = (pen > 65535) ? 16'hFFFF : pen[15:0];
        corr = (pen > slop_r) ? (((pen - slop_r) * pct_r) >> 8) : 0;
        mag = corr * fan / den;
        r.shift_a = clamp16(-sgn * mag);
        mag = corr * fbn / den;
        r.shift_b = clamp16(sgn * mag);
        v = sgn * (comp_s(vb, axis) - comp_s(va, axis));
        if (v > 0)
            return r;
        base = (256 + rest_r) * (-v);
        da = base * fan / (den * 256);
        db = base * fbn / (den * 256);
        r.vel_a[axis*16 +: 16] = clamp16(comp_s(va, axis) - sgn * da);
        r.vel_b[axis*16 +: 16] = clamp16(comp_s(vb, axis) + sgn * db);
        return r;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on %s: got %h, want %h", field, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        if (!rst_n)
        begin
            pct_r  = PCT_RESET;
            slop_r = SLOP_RESET;
            rest_r = REST_RESET;
            contact_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                case (cfg_reg_t'(cfg.index))
                    REG_CORRECTION_PERCENT: pct_r  = cfg.data[PCT_W-1:0];
                    REG_PENETRATION_SLOP:   slop_r = cfg.data[SLOP_W-1:0];
                    REG_RESTITUTION:        rest_r = cfg.data[REST_W-1:0];
                    default: ;
                endcase
            if (result.valid && result.ready)
            begin
                if (contact_q.size() == 0)
                    report("unexpected item", 0, 0);
                else
                begin
                    want = contact_q.pop_front();
                    if (result.contact_found !== want.found)
                        report("contact_found", result.contact_found, want.found);
                    if (result.normal_axis !== want.axis)
                        report("normal_axis", result.normal_axis, want.axis);
                    if (result.normal_negative !== want.negative)
                        report("normal_negative", result.normal_negative, want.negative);
                    if (result.penetration !== want.pen)
                        report("penetration", result.penetration, want.pen);
                    if (result.shift_a !== want.shift_a)
                        report("shift_a", result.shift_a, want.shift_a);
                    if (result.shift_b !== want.shift_b)
                        report("shift_b", result.shift_b, want.shift_b);
                    if (result.new_vel_a !== want.vel_a)
                        report("new_vel_a", result.new_vel_a, want.vel_a);
                    if (result.new_vel_b !== want.vel_b)
                        report("new_vel_b", result.new_vel_b, want.vel_b);
                end
            end
            if (pair.valid && pair.ready)
                contact_q.push_back(resolve_contact(pair.center_a, pair.center_b,
                    pair.half_a, pair.half_b, pair.scale_a, pair.scale_b,
                    pair.vel_a, pair.vel_b, pair.mass_a, pair.mass_b,
                    pair.flags_a, pair.flags_b));
        end
        pending = contact_q.size();
    end

endmodule

`default_nettype wire

/* tb/tb_aabb_contact_impulse_resolver.sv */
// Testbench top of the AABB contact impulse resolver: clock, reset, stimulus and verdict.
// Depends on aacir_pkg, aacir_if, the resolver RTL and aacir_contact_checker.
`default_nettype none

module tb_aabb_contact_impulse_resolver;
    import aacir_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [VEC_W-1:0]   ca, cb, ha, hb, sa, sb, va, vb;
        logic [MASS_W-1:0]  ma, mb;
        logic [FLAGS_W-1:0] fa, fb;
    } body_pair_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_req;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    aacir_pair_if   pair();
    aacir_result_if result();
    aacir_cfg_if    cfg();

    aabb_contact_impulse_resolver u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result),
        .cfg    (cfg)
    );

    aacir_contact_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // End the run when no channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((pair.valid && pair.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                result.ready = 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else
                result.ready = 1'b1;
        end
    end

    function automatic logic [VEC_W-1:0] rand_vec();
        return {$urandom, $urandom};
    endfunction

    function automatic body_pair_t base_pair();
        body_pair_t p;
        p.ca = '0;
        p.cb = {16'd0, 16'd0, 16'd100};
        p.ha = {3{16'd512}};
        p.hb = {3{16'd512}};
        p.sa = {3{16'd1024}};
        p.sb = {3{16'd1024}};
        p.va = {16'd0, 16'd0, 16'd100};
        p.vb = '0;
        p.ma = 16'd256;
        p.mb = 16'd256;
        p.fa = 2'b10;
        p.fb = 2'b10;
        return p;
    endfunction

    function automatic body_pair_t rand_pair();
        body_pair_t p;
        int         c;
        int         dlt;
        p.va = rand_vec();
        p.vb = rand_vec();
        p.ma = $urandom;
        p.mb = $urandom;
        p.fa = $urandom;
        p.fb = $urandom;
        if ($urandom_range(0, 9) < 3)
        begin
            p.ca = rand_vec();
            p.cb = rand_vec();
            p.ha = rand_vec();
            p.hb = rand_vec();
            p.sa = rand_vec();
            p.sb = rand_vec();
            return p;
        end
        // Mostly overlapping boxes of moderate size, so contacts dominate.
        for (int ax = 0; ax < 3; ax++)
        begin
            c = $urandom_range(0, 16384) - 8192;
            dlt = $urandom_range(0, 5000) - 2500;
            p.ca[ax*16 +: 16] = c;
            p.cb[ax*16 +: 16] = c + dlt;
            p.ha[ax*16 +: 16] = $urandom_range(64, 4096);
            p.hb[ax*16 +: 16] = $urandom_range(64, 4096);
            p.sa[ax*16 +: 16] = $urandom_range(256, 2048);
            p.sb[ax*16 +: 16] = $urandom_range(256, 2048);
        end
        if ($urandom_range(0, 9) < 8)
            p.fa[1] = 1'b1;
        if ($urandom_range(0, 3) == 0)
            p.ma = $urandom_range(0, 3);
        return p;
    endfunction

    task automatic send_pair(input body_pair_t p);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            pair.valid = 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
        @(negedge clk);
        pair.valid = 1'b1;
        pair.center_a = p.ca;
        pair.center_b = p.cb;
        pair.half_a = p.ha;
        pair.half_b = p.hb;
        pair.scale_a = p.sa;
        pair.scale_b = p.sb;
        pair.vel_a = p.va;
        pair.vel_b = p.vb;
        pair.mass_a = p.ma;
        pair.mass_b = p.mb;
        pair.flags_a = p.fa;
        pair.flags_b = p.fb;
        do
            @(posedge clk);
        while (!pair.ready);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        pair.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_regs(input int pct, input int slop, input int rest);
        drain();
        write_reg(REG_CORRECTION_PERCENT, pct);
        write_reg(REG_PENETRATION_SLOP, slop);
        write_reg(REG_RESTITUTION, rest);
    endtask

    task automatic directed_pairs();
        body_pair_t p;
        send_pair(base_pair());
        p = base_pair(); p.cb = {16'd0, 16'd0, 16'hFF9C};           send_pair(p);
        p = base_pair(); p.cb = '0;                                  send_pair(p);
        p = base_pair(); p.cb = {16'd0, 16'd200, 16'd0};             send_pair(p);
        p = base_pair(); p.cb = {16'hFED4, 16'd0, 16'd0};
        p.va = {16'hFF00, 16'd0, 16'd0};                             send_pair(p);
        // tie between y and z goes to y
        p = base_pair(); p.cb = {16'd200, 16'd200, 16'd0};           send_pair(p);
        p = base_pair(); p.fa = 2'b00; p.fb = 2'b00;                 send_pair(p);
        p = base_pair(); p.fa = 2'b11; p.fb = 2'b11;                 send_pair(p);
        p = base_pair(); p.fa = 2'b01; p.fb = 2'b10;                 send_pair(p);
        p = base_pair(); p.fb = 2'b11;                               send_pair(p);
        p = base_pair(); p.ma = '0; p.mb = '0;                       send_pair(p);
        p = base_pair(); p.ma = 16'hFFFF; p.mb = 16'd1;              send_pair(p);
        p = base_pair(); p.va = {16'd0, 16'd0, 16'hFF9C};            send_pair(p);
        p = base_pair(); p.va = '0;                                  send_pair(p);
        // touching boxes have zero overlap
        p = base_pair(); p.cb = {16'd0, 16'd0, 16'd1024};            send_pair(p);
        p = base_pair(); p.ha = '1; p.hb = '1; p.sa = '1; p.sb = '1;
        p.cb = '0;                                                   send_pair(p);
        p = base_pair(); p.va = {16'd0, 16'd0, 16'h7FFF};
        p.vb = {16'd0, 16'd0, 16'h8000};                             send_pair(p);
        p = base_pair(); p.cb = {16'd0, 16'd0, 16'hFF00};
        p.va = {16'd0, 16'd0, 16'h8000}; p.vb = {16'd0, 16'd0, 16'h7FFF};
        send_pair(p);
        p.ca = '1; p.cb = '1; p.ha = '1; p.hb = '1; p.sa = '1; p.sb = '1;
        p.va = '1; p.vb = '1; p.ma = '1; p.mb = '1; p.fa = '1; p.fb = 2'b10;
        send_pair(p);
        p.ca = '0; p.cb = '0; p.ha = '0; p.hb = '0; p.sa = '0; p.sb = '0;
        p.va = '0; p.vb = '0; p.ma = '0; p.mb = '0; p.fa = '0; p.fb = '0;
        send_pair(p);
    endtask

    task automatic random_pairs(input int count);
        repeat (count) send_pair(rand_pair());
    endtask

    initial
    begin
        rst_n = 1'b0;
        quiet = 0;
        hold_req = 0;
        idle_cycles = 0;
        pair.valid = 1'b0;
        pair.center_a = '0;
        pair.center_b = '0;
        pair.half_a = '0;
        pair.half_b = '0;
        pair.scale_a = '0;
        pair.scale_b = '0;
        pair.vel_a = '0;
        pair.vel_b = '0;
        pair.mass_a = '0;
        pair.mass_b = '0;
        pair.flags_a = '0;
        pair.flags_b = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_CORRECTION_PERCENT;
        cfg.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_pairs();
        random_pairs(90);

        set_regs(256, 0, 256);
        directed_pairs();
        hold_req = 1;
        random_pairs(110);

        set_regs(0, 1023, 0);
        random_pairs(100);

        set_regs(16'h01FF, 16'h03FF, 16'h01FF);
        random_pairs(100);

        set_regs($urandom, $urandom, $urandom);
        random_pairs(100);

        set_regs(51, 1, 0);
        random_pairs(100);

        set_regs(256, 0, 256);
        quiet = 1;
        random_pairs(100);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* aabb_contact_impulse_resolver.f */
sv/aacir_pkg.sv
sv/aacir_if.sv
sv/aacir_front.sv
sv/aacir_queue.sv
sv/aacir_divider.sv
sv/aacir_back.sv
sv/aabb_contact_impulse_resolver.sv
sv/aacir_checker.sv
tb/aacir_contact_checker.sv
tb/tb_aabb_contact_impulse_resolver.sv
